// ===== src/kroot_pkg.sv =====
package kroot_pkg;

  localparam int RADICAND_W = 64;
  localparam int EXPONENT_W = 7;
  localparam int ROOT_W     = 64;

endpackage

// ===== src/kroot_if.sv =====
interface kroot_in_if;
  logic                               valid;
  logic                               ready;
  logic [kroot_pkg::RADICAND_W-1:0]   radicand;
  logic [kroot_pkg::EXPONENT_W-1:0]   exponent;

  modport source (output valid, radicand, exponent, input ready);
  modport sink   (input valid, radicand, exponent, output ready);
endinterface

interface kroot_out_if;
  logic                           valid;
  logic                           ready;
  logic [kroot_pkg::ROOT_W-1:0]   root;

  modport source (output valid, root, input ready);
  modport sink   (input valid, root, output ready);
endinterface

// ===== src/integer_kth_root_bisection.sv =====
// Channel   Direction  Payload                         Transaction when
// in_ch     sink       radicand[63:0], exponent[6:0]   valid && ready
// out_ch    source     root[63:0]                      valid && ready
//
// Radicand 0 or 1, exponent 0 or 1 or at least DATA_WIDTH: accept, then straight to the load state.
// Otherwise up to DATA_WIDTH bisection steps, each a midpoint state and up to exponent multiplications
// per step, each through the MUL, ADD and CHK states; then a closing midpoint state and the load state.
// All multiplications go through one half-width multiplier, four partial products each.
// Synchronous reset clears the sequencer and the output valid flag.
// The input is ready only while idle; a held result stalls the sequencer in its load cycle.
module integer_kth_root_bisection #(
  parameter int DATA_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  kroot_in_if.sink           in_ch,
  kroot_out_if.source        out_ch
);
  import kroot_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int HALF = (DW + 1) / 2;
  localparam int W2   = 2 * HALF;
  localparam int SUMW = 2 * W2;
  localparam int CW   = $clog2(DW);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MID  = 6'b000010,
    S_MUL  = 6'b000100,
    S_ADD  = 6'b001000,
    S_CHK  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t            state;
  logic [DW-1:0]     x;
  logic [DW-1:0]     lo;
  logic [DW-1:0]     hi;
  logic [DW-1:0]     mid;
  logic [DW-1:0]     acc;
  logic [CW-1:0]     k;
  logic [CW-1:0]     cnt;
  logic [1:0]        idx;
  logic [W2-1:0]     pp;
  logic [1:0]        ppsh;
  logic              pp_v;
  logic [SUMW-1:0]   sum;
  logic              out_valid;
  logic [ROOT_W-1:0] out_root;

  logic [DW-1:0]     in_x;
  logic [W2-1:0]     acc_ext;
  logic [W2-1:0]     mid_ext;
  logic [HALF-1:0]   mul_a;
  logic [HALF-1:0]   mul_b;
  logic [W2-1:0]     mult;
  logic [SUMW-1:0]   pp_shifted;
  logic [DW-1:0]     diff;
  logic              over;

  assign in_x     = in_ch.radicand[DW-1:0];
  assign acc_ext  = W2'(acc);
  assign mid_ext  = W2'(mid);
  assign mul_a    = idx[1] ? acc_ext[W2-1:HALF] : acc_ext[HALF-1:0];
  assign mul_b    = idx[0] ? mid_ext[W2-1:HALF] : mid_ext[HALF-1:0];
  assign mult     = W2'(mul_a) * W2'(mul_b);
  assign diff     = hi - lo;
  assign over     = (|sum[SUMW-1:DW]) || (sum[DW-1:0] > x);

  always_comb begin
    case (ppsh)
      2'd0:    pp_shifted = SUMW'(pp);
      2'd1:    pp_shifted = SUMW'(pp) << HALF;
      default: pp_shifted = SUMW'(pp) << W2;
    endcase
  end

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.root  = out_root;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pp_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            x <= in_x;
            k <= in_ch.exponent[CW-1:0];
            if (in_x == '0) begin
              lo    <= '0;
              state <= S_DONE;
            end else if (in_ch.exponent <= EXPONENT_W'(1) || in_x == DW'(1)) begin
              lo    <= in_x;
              state <= S_DONE;
            end else if (in_ch.exponent >= EXPONENT_W'(DATA_WIDTH)) begin
              lo    <= DW'(1);
              state <= S_DONE;
            end else begin
              lo    <= DW'(1);
              hi    <= in_x;
              state <= S_MID;
            end
          end
        end
        S_MID: begin
          if (diff > DW'(1)) begin
            mid   <= lo + (diff >> 1);
            acc   <= DW'(1);
            cnt   <= k;
            idx   <= 2'd0;
            pp_v  <= 1'b0;
            state <= S_MUL;
          end else begin
            state <= S_DONE;
          end
        end
        S_MUL: begin
          pp   <= mult;
          ppsh <= 2'(idx[1]) + 2'(idx[0]);
          pp_v <= 1'b1;
          idx  <= idx + 2'd1;
          if (pp_v) begin
            sum <= sum + pp_shifted;
          end else begin
            sum <= '0;
          end
          if (idx == 2'd3) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          sum   <= sum + pp_shifted;
          pp_v  <= 1'b0;
          state <= S_CHK;
        end
        S_CHK: begin
          if (over) begin
            hi    <= mid;
            state <= S_MID;
          end else if (cnt == CW'(1)) begin
            lo    <= mid;
            state <= S_MID;
          end else begin
            acc   <= sum[DW-1:0];
            cnt   <= cnt - CW'(1);
            state <= S_MUL;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_root  <= ROOT_W'(lo);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The bisection interval never collapses while a step is pending.
  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    (state == S_MID) |-> (lo < hi))
    else $error("bisection bounds out of order");

  // The midpoint under test lies strictly inside the interval.
  a_mid_inside: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK) |-> (mid > lo && mid < hi))
    else $error("midpoint outside the bisection interval");

  // An accepted transaction always starts work.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (state != S_IDLE))
    else $error("accepted transaction left the sequencer idle");
`endif

endmodule

// ===== verif/integer_kth_root_bisection_test.sv =====
`timescale 1ns / 1ps

module integer_kth_root_bisection_test;
  import kroot_pkg::*;

  typedef logic [RADICAND_W-1:0] radicand_t;
  typedef logic [EXPONENT_W-1:0] exponent_t;
  typedef logic [ROOT_W-1:0]     root_t;

  localparam radicand_t WORD_MAX    = '1;
  localparam int        WORD_BITS   = 64;
  localparam int        STALL_PCT   = 35;
  localparam int        REPORT_MAX  = 10;
  localparam int        DRAIN_WAIT  = 50;
  localparam longint    CYCLE_LIMIT = 60_000_000;

  logic clk;
  logic rst;

  kroot_in_if  in_ch();
  kroot_out_if out_ch();

  integer_kth_root_bisection dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  root_t  expected_roots[$];
  int     mismatches = 0;
  bit     no_stalls;
  longint cycle_count = 0;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic bit power_above(radicand_t base, exponent_t k, radicand_t limit);
    logic [2*WORD_BITS-1:0] acc;
    acc = 1;
    for (int i = 0; i < k; i++) begin
      acc = acc * base;
      if (acc > WORD_MAX) begin
        return 1'b1;
      end
    end
    return acc > limit;
  endfunction

  function automatic root_t floor_root(radicand_t x, exponent_t k);
    radicand_t lo;
    radicand_t hi;
    radicand_t mid;
    if (x == 0) begin
      return '0;
    end
    if (k <= 1 || x == 1) begin
      return x;
    end
    if (k >= WORD_BITS) begin
      return 1;
    end
    lo = 1;
    hi = x;
    while (hi - lo > 1) begin
      mid = lo + ((hi - lo) >> 1);
      if (power_above(mid, k, x)) begin
        hi = mid;
      end else begin
        lo = mid;
      end
    end
    return lo;
  endfunction

  function automatic radicand_t int_power(radicand_t base, exponent_t k);
    radicand_t acc;
    acc = 1;
    for (int i = 0; i < k; i++) begin
      acc = acc * base;
    end
    return acc;
  endfunction

  // The caller stands at a falling edge and is left at the falling edge after the transaction.
  task automatic send_item(radicand_t x, exponent_t k);
    while (!no_stalls && $urandom_range(99) < STALL_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.radicand <= x;
    in_ch.exponent <= k;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    expected_roots.insert(expected_roots.size(), floor_root(x, k));
    @(negedge clk);
  endtask

  task automatic send_random_item();
    radicand_t x;
    radicand_t rmax;
    radicand_t r;
    exponent_t k;
    int        pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      // A perfect power or one of its neighbours, where the bisection is most easily wrong.
      k    = (pick < 20) ? exponent_t'($urandom_range(8, 2))
                         : exponent_t'($urandom_range(63, 9));
      rmax = floor_root(WORD_MAX, k);
      r    = radicand_t'($urandom_range(rmax[31:0], 2));
      x    = int_power(r, k) + radicand_t'($urandom_range(2)) - 1;
    end else begin
      x = {$urandom, $urandom} >> $urandom_range(WORD_BITS - 1);
      if (pick < 70) begin
        k = exponent_t'($urandom_range(8, 2));
      end else if (pick < 85) begin
        k = exponent_t'($urandom_range(63, 9));
      end else if (pick < 93) begin
        k = exponent_t'($urandom_range(127, 64));
      end else begin
        k = exponent_t'($urandom_range(1));
      end
    end
    send_item(x, k);
  endtask

  task automatic test_special_cases();
    send_item(0, 2);
    send_item(0, 127);
    send_item(0, 0);
    send_item(1, 5);
    send_item(1, 127);
    send_item(WORD_MAX, 1);
    send_item(64'd12345, 0);
    send_item(WORD_MAX, 0);
    send_item(WORD_MAX, 64);
    send_item(64'd2, 127);
    send_item(WORD_MAX, 63);
    send_item(64'h8000_0000_0000_0000, 63);
    send_item(64'h7FFF_FFFF_FFFF_FFFF, 63);
    send_item(WORD_MAX, 2);
    send_item(WORD_MAX, 3);
    send_item(64'd1_000_000_000_000_000_000, 2);
    send_item(64'd999_999_999_999_999_999, 2);
    send_item(int_power(3, 40), 40);
    send_item(int_power(3, 40) - 1, 40);
    send_item(64'd2, 2);
    send_item(64'd3, 2);
    send_item(64'd4, 2);
    send_item(64'h1_0000_0000, 32);
    send_item(64'h8000_0000_0000_0000, 2);
  endtask

  task automatic test_random_items(int count);
    repeat (count) begin
      send_random_item();
    end
  endtask

  task automatic test_back_to_back(int count);
    no_stalls = 1'b1;
    repeat (count) begin
      send_random_item();
    end
    no_stalls = 1'b0;
  endtask

  always @(negedge clk) begin
    out_ch.ready <= no_stalls || ($urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    root_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_roots.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("Unexpected result transaction: root %0d", out_ch.root);
        end
      end else begin
        want = expected_roots.pop_front();
        if (out_ch.root !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("Root mismatch: expected %0d, actual %0d", want, out_ch.root);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    no_stalls      = 1'b0;
    rst            = 1'b1;
    in_ch.valid    = 1'b0;
    in_ch.radicand = '0;
    in_ch.exponent = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_special_cases();
    test_random_items(250);
    test_back_to_back(100);
    test_random_items(130);

    in_ch.valid <= 1'b0;
    while (expected_roots.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_WAIT) @(negedge clk);

    if (mismatches == 0 && expected_roots.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
